// ===== sv/sld_pkg.sv =====
// ----------------------------------------------------------------------------
// sld_pkg
// Types, codes and CRC helpers for the sync/length/CRC deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package sld_pkg;

   localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
   localparam logic [7:0]  SYNC_SECOND = 8'h55;
   localparam logic [15:0] CRC_POLY    = 16'h8408;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [8:0]  MAX_PAYLOAD_RESET = 9'd256;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_SYNC2   = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CRC_LO  = 3'd5,
      PH_CRC_HI  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA    = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_CRC_ERR = 2'd2,
      KIND_LEN_ERR = 2'd3
   } kind_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [15:0] frame_length;
      logic [31:0] good_frames;
      logic [31:0] crc_error_count;
      logic [31:0] length_error_count;
   } result_type;

   // One byte of reflected CRC-16/X-25.
   function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                              input logic [7:0]  data);
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

   // Sync hunter step from one of the hunting phases.
   function automatic phase_type hunt_next(input phase_type p, input logic [7:0] b);
      phase_type nxt;
      if (p == PH_SYNC2 && b == SYNC_SECOND) begin
         nxt = PH_LEN_LO;
      end else if (b == SYNC_FIRST) begin
         nxt = PH_SYNC2;
      end else begin
         nxt = PH_HUNT;
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

// ===== sv/sld_core.sv =====
// ----------------------------------------------------------------------------
// sld_core
// Frame state machine: sync hunt, length check, CRC and counters. Advances
// by one byte on each step and gives that byte's result combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         rx_byte,
   input  wire logic [8:0]         max_payload,
   output sld_pkg::result_type     result
);

   sld_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  len_lo_ff, len_lo_in;
   logic [8:0]  pay_len_ff, pay_len_in;
   logic [8:0]  remain_ff, remain_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic [31:0] good_ff, good_in;
   logic [31:0] crc_err_ff, crc_err_in;
   logic [31:0] len_err_ff, len_err_in;

   logic [15:0] len_full;
   logic [15:0] crc_rx;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= sld_pkg::PH_HUNT;
         len_lo_ff  <= '0;
         pay_len_ff <= '0;
         remain_ff  <= '0;
         crc_ff     <= sld_pkg::CRC_INIT;
         crc_lo_ff  <= '0;
         good_ff    <= '0;
         crc_err_ff <= '0;
         len_err_ff <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         len_lo_ff  <= len_lo_in;
         pay_len_ff <= pay_len_in;
         remain_ff  <= remain_in;
         crc_ff     <= crc_in;
         crc_lo_ff  <= crc_lo_in;
         good_ff    <= good_in;
         crc_err_ff <= crc_err_in;
         len_err_ff <= len_err_in;
      end
   end

   assign len_full = {rx_byte, len_lo_ff};
   assign crc_rx   = {rx_byte, crc_lo_ff};

   always_comb begin
      phase_in   = phase_ff;
      len_lo_in  = len_lo_ff;
      pay_len_in = pay_len_ff;
      remain_in  = remain_ff;
      crc_in     = crc_ff;
      crc_lo_in  = crc_lo_ff;
      good_in    = good_ff;
      crc_err_in = crc_err_ff;
      len_err_in = len_err_ff;

      result.valid        = 1'b0;
      result.kind         = sld_pkg::KIND_DATA;
      result.data_byte    = '0;
      result.frame_length = {7'd0, pay_len_ff};

      unique case (phase_ff)
         sld_pkg::PH_SYNC2: begin
            phase_in = sld_pkg::hunt_next(sld_pkg::PH_SYNC2, rx_byte);
         end
         sld_pkg::PH_LEN_LO: begin
            len_lo_in = rx_byte;
            phase_in  = sld_pkg::PH_LEN_HI;
         end
         sld_pkg::PH_LEN_HI: begin
            if (len_full > {7'd0, max_payload}) begin
               // rescan both length bytes through the sync hunter
               len_err_in          = len_err_ff + 32'd1;
               phase_in            = sld_pkg::hunt_next(
                                        sld_pkg::hunt_next(sld_pkg::PH_HUNT, len_lo_ff),
                                        rx_byte);
               result.valid        = 1'b1;
               result.kind         = sld_pkg::KIND_LEN_ERR;
               result.frame_length = len_full;
            end else begin
               pay_len_in = len_full[8:0];
               remain_in  = len_full[8:0];
               crc_in     = sld_pkg::CRC_INIT;
               phase_in   = (len_full[8:0] == 9'd0) ? sld_pkg::PH_CRC_LO
                                                    : sld_pkg::PH_PAYLOAD;
            end
         end
         sld_pkg::PH_PAYLOAD: begin
            crc_in    = sld_pkg::crc_update(crc_ff, rx_byte);
            remain_in = remain_ff - 9'd1;
            if (remain_in == 9'd0) begin
               phase_in = sld_pkg::PH_CRC_LO;
            end
            result.valid     = 1'b1;
            result.kind      = sld_pkg::KIND_DATA;
            result.data_byte = rx_byte;
         end
         sld_pkg::PH_CRC_LO: begin
            crc_lo_in = rx_byte;
            phase_in  = sld_pkg::PH_CRC_HI;
         end
         sld_pkg::PH_CRC_HI: begin
            phase_in     = sld_pkg::PH_HUNT;
            result.valid = 1'b1;
            if (crc_rx == ~crc_ff) begin
               good_in     = good_ff + 32'd1;
               result.kind = sld_pkg::KIND_GOOD;
            end else begin
               crc_err_in  = crc_err_ff + 32'd1;
               result.kind = sld_pkg::KIND_CRC_ERR;
            end
         end
         default: begin
            phase_in = sld_pkg::hunt_next(sld_pkg::PH_HUNT, rx_byte);
         end
      endcase

      result.good_frames        = good_in;
      result.crc_error_count    = crc_err_in;
      result.length_error_count = len_err_in;
   end

endmodule

`default_nettype wire

// ===== sv/sync_length_crc_deframer_top.sv =====
// ----------------------------------------------------------------------------
// sync_length_crc_deframer_top
// Byte-serial deframer for AA 55 / length / payload / CRC-16/X-25 frames.
// ----------------------------------------------------------------------------
// Takes one byte per cycle. A byte is captured into an input register, runs
// through the frame state machine and CRC update, and any result lands in an
// output register that drives rsp_valid, so each result passes the input and
// then the output register before its rsp transfer. Throughput is one byte per
// cycle as long as the result side takes results; a held result stops the state
// machine, and req_ready drops once the input register holds a byte.
// Payload bytes come out as they arrive, followed by one good or CRC-error
// verdict per frame; oversize lengths give a length-error result. The
// max_payload register is written through the csr port, which is always ready;
// the user must write it only while the block is idle, as the block does not enforce it.
`default_nettype none

module sync_length_crc_deframer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [15:0]      rsp_frame_length,
   output logic [31:0]      rsp_good_frames,
   output logic [31:0]      rsp_crc_error_count,
   output logic [31:0]      rsp_length_error_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [8:0]  csr_max_payload
);

   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic [8:0]          max_payload_ff;
   logic                step;
   sld_pkg::result_type result;
   sld_pkg::result_type rsp_ff;
   logic                rsp_valid_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= sld_pkg::MAX_PAYLOAD_RESET;
      end else if (csr_valid) begin
         max_payload_ff <= csr_max_payload;
      end
   end

   // advance a byte when the output register is free or draining
   assign step      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   sld_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .rx_byte     (in_byte_ff),
      .max_payload (max_payload_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= result.valid;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_kind               = rsp_ff.kind;
   assign rsp_data_byte          = rsp_ff.data_byte;
   assign rsp_frame_length       = rsp_ff.frame_length;
   assign rsp_good_frames        = rsp_ff.good_frames;
   assign rsp_crc_error_count    = rsp_ff.crc_error_count;
   assign rsp_length_error_count = rsp_ff.length_error_count;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sync/length/CRC deframer. Byte streams of
// framed packets, oversize headers, noise and cut-off frames go in; each
// payload byte, verdict and length error coming out is checked against a
// cycle-free software model of the framer kept alongside.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sld_pkg::*;

   localparam int CLOCK_PERIOD    = 12;
   localparam int RESET_CYCLES    = 9;
   localparam int SETTLE_CYCLES   = 6;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int RANDOM_BYTES    = 550;
   localparam int CFG_INTERVAL    = 350;

   typedef logic [7:0] byte_q_type[$];

   typedef struct {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [15:0] frame_length;
      logic [31:0] good_frames;
      logic [31:0] crc_errors;
      logic [31:0] length_errors;
   } frame_event_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [15:0] rsp_frame_length;
   logic [31:0] rsp_good_frames;
   logic [31:0] rsp_crc_error_count;
   logic [31:0] rsp_length_error_count;
   logic        csr_valid;
   logic        csr_ready;
   logic [8:0]  csr_max_payload;

   // deframer model state
   phase_type   rx_phase    = PH_HUNT;
   logic [7:0]  len_low     = 8'h00;
   logic [8:0]  pay_len     = 9'd0;
   logic [8:0]  bytes_left  = 9'd0;
   logic [15:0] crc_acc     = CRC_INIT;
   logic [7:0]  crc_lo      = 8'h00;
   logic [31:0] good_cnt    = 32'd0;
   logic [31:0] crc_err_cnt = 32'd0;
   logic [31:0] len_err_cnt = 32'd0;
   logic [8:0]  max_len     = MAX_PAYLOAD_RESET;

   frame_event_type expected_events[$];
   byte_q_type      tx_bytes;
   int              failures         = 0;
   int              stalled_cycles   = 0;
   bit              no_idle          = 1'b0;
   bit              rsp_hold_request = 1'b0;

   sync_length_crc_deframer_top DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_rx_byte            (req_rx_byte),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_kind               (rsp_kind),
      .rsp_data_byte          (rsp_data_byte),
      .rsp_frame_length       (rsp_frame_length),
      .rsp_good_frames        (rsp_good_frames),
      .rsp_crc_error_count    (rsp_crc_error_count),
      .rsp_length_error_count (rsp_length_error_count),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_max_payload        (csr_max_payload)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // Model
   // ------------------------------------------------------------------------
   function automatic logic [15:0] x25_byte(input logic [15:0] acc, input logic [7:0] d);
      logic [15:0] r;
      r = acc ^ {8'h00, d};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic phase_type sync_track(input phase_type p, input logic [7:0] b);
      if (p == PH_SYNC2 && b == SYNC_SECOND) begin
         return PH_LEN_LO;
      end
      return (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
   endfunction

   function automatic void post_event(input kind_type k, input logic [7:0] d,
                                      input logic [15:0] n);
      frame_event_type ev;
      ev.kind          = k;
      ev.data_byte     = d;
      ev.frame_length  = n;
      ev.good_frames   = good_cnt;
      ev.crc_errors    = crc_err_cnt;
      ev.length_errors = len_err_cnt;
      expected_events.push_back(ev);
   endfunction

   function automatic void deframe_step(input logic [7:0] b);
      logic [15:0] hdr_len;
      case (rx_phase)
         PH_SYNC2: begin
            rx_phase = sync_track(PH_SYNC2, b);
         end
         PH_LEN_LO: begin
            len_low  = b;
            rx_phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            hdr_len = {b, len_low};
            if (hdr_len > {7'd0, max_len}) begin
               len_err_cnt++;
               // rescan both length bytes as if they were hunt bytes
               rx_phase = sync_track(sync_track(PH_HUNT, len_low), b);
               post_event(KIND_LEN_ERR, 8'h00, hdr_len);
            end else begin
               pay_len    = hdr_len[8:0];
               bytes_left = hdr_len[8:0];
               crc_acc    = CRC_INIT;
               rx_phase   = (hdr_len == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            crc_acc    = x25_byte(crc_acc, b);
            bytes_left = bytes_left - 9'd1;
            if (bytes_left == 9'd0) begin
               rx_phase = PH_CRC_LO;
            end
            post_event(KIND_DATA, b, {7'd0, pay_len});
         end
         PH_CRC_LO: begin
            crc_lo   = b;
            rx_phase = PH_CRC_HI;
         end
         PH_CRC_HI: begin
            rx_phase = PH_HUNT;
            if ({b, crc_lo} == ~crc_acc) begin
               good_cnt++;
               post_event(KIND_GOOD, 8'h00, {7'd0, pay_len});
            end else begin
               crc_err_cnt++;
               post_event(KIND_CRC_ERR, 8'h00, {7'd0, pay_len});
            end
         end
         default: begin
            rx_phase = sync_track(PH_HUNT, b);
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stream building
   // ------------------------------------------------------------------------
   function automatic byte_q_type random_body(input int n);
      byte_q_type q;
      repeat (n) q.push_back(8'($urandom_range(255, 0)));
      return q;
   endfunction

   // Append a full frame; a nonzero crc_flip corrupts the trailer.
   function automatic void queue_frame(input byte_q_type body, input logic [15:0] crc_flip);
      logic [15:0] n;
      logic [15:0] crc;
      n   = 16'(body.size());
      crc = CRC_INIT;
      tx_bytes.push_back(SYNC_FIRST);
      tx_bytes.push_back(SYNC_SECOND);
      tx_bytes.push_back(n[7:0]);
      tx_bytes.push_back(n[15:8]);
      foreach (body[i]) begin
         crc = x25_byte(crc, body[i]);
         tx_bytes.push_back(body[i]);
      end
      crc = ~crc ^ crc_flip;
      tx_bytes.push_back(crc[7:0]);
      tx_bytes.push_back(crc[15:8]);
   endfunction

   function automatic void queue_header(input logic [7:0] lo, input logic [7:0] hi);
      tx_bytes.push_back(SYNC_FIRST);
      tx_bytes.push_back(SYNC_SECOND);
      tx_bytes.push_back(lo);
      tx_bytes.push_back(hi);
   endfunction

   function automatic int draw_gap();
      int r;
      if (no_idle) begin
         return 0;
      end
      r = $urandom_range(99, 0);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // ------------------------------------------------------------------------
   // Channel drivers (entered and left at a falling edge)
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b);
      int gap;
      req_rx_byte <= b;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      deframe_step(b);
      @(negedge clock);
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_queued();
      while (tx_bytes.size() != 0) begin
         send_byte(tx_bytes.pop_front());
      end
   endtask

   // Drop valid, wait for every result, then let the pipe empty.
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_max_payload(input logic [8:0] v);
      csr_max_payload <= v;
      csr_valid       <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      max_len = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------
   initial begin : rsp_pacing
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            stall_left       = RSP_HOLD_CYCLES;
         end else if (stall_left == 0 && rsp_ready) begin
            stall_left = draw_gap();
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic void check_field(input string name, input logic [31:0] exp,
                                       input logic [31:0] act);
      if (act !== exp) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      frame_event_type ev;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_events.size() == 0) begin
            $error("result with nothing pending: kind %0d data 0x%0h", rsp_kind,
                   rsp_data_byte);
            failures++;
         end else begin
            ev = expected_events.pop_front();
            check_field("kind", 32'(ev.kind), 32'(rsp_kind));
            check_field("data_byte", 32'(ev.data_byte), 32'(rsp_data_byte));
            check_field("frame_length", 32'(ev.frame_length), 32'(rsp_frame_length));
            check_field("good_frames", ev.good_frames, rsp_good_frames);
            check_field("crc_error_count", ev.crc_errors, rsp_crc_error_count);
            check_field("length_error_count", ev.length_errors, rsp_length_error_count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed_frames();
      // repeated sync byte, one-byte payload of all ones
      tx_bytes.push_back(SYNC_FIRST);
      queue_frame('{8'hFF}, 16'h0000);
      // length bytes AA 55 overflow and resync straight into a length
      tx_bytes.push_back(SYNC_FIRST);
      tx_bytes.push_back(SYNC_SECOND);
      queue_frame('{8'h00, 8'h7F}, 16'h0100);
      // high length byte AA overflows; the following 55 completes a sync
      queue_header(8'h10, SYNC_FIRST);
      tx_bytes.push_back(SYNC_SECOND);
      tx_bytes.push_back(8'h00);
      tx_bytes.push_back(8'h00);
      // empty payload, CRC of nothing
      tx_bytes.push_back(8'h00);
      tx_bytes.push_back(8'h00);
      send_queued();
   endtask

   task automatic test_length_limits();
      byte_q_type none;
      settle();
      write_max_payload(9'd0);
      queue_frame(none, 16'h0000);
      queue_header(8'h01, 8'h00);
      send_queued();
      settle();
      write_max_payload(9'd506);
      queue_frame(random_body(506), 16'h0000);
      queue_header(8'hFB, 8'h01);
      queue_frame(random_body(3), 16'h0000);
      send_queued();
      settle();
      write_max_payload(9'd511);
      queue_frame(random_body(511), 16'h8000);
      send_queued();
      settle();
      write_max_payload(9'd1);
      queue_frame(random_body(1), 16'h0000);
      queue_header(8'h02, 8'h00);
      queue_frame(none, 16'h0001);
      send_queued();
      settle();
      write_max_payload(MAX_PAYLOAD_RESET);
   endtask

   // Hold the result side while the sender keeps offering bytes.
   task automatic test_output_backpressure();
      settle();
      no_idle          = 1'b1;
      rsp_hold_request = 1'b1;
      queue_frame(random_body(48), 16'h0000);
      send_queued();
      no_idle = 1'b0;
      settle();
   endtask

   function automatic logic [8:0] pick_max();
      case ($urandom_range(9, 0))
         0:       return 9'd0;
         1:       return 9'd1;
         2:       return 9'd506;
         3:       return 9'd511;
         4:       return MAX_PAYLOAD_RESET;
         default: return 9'($urandom_range(511, 16));
      endcase
   endfunction

   task automatic test_random_stream();
      int counted;
      int next_cfg;
      int pick;
      int n;
      logic [15:0] bad_len;
      counted  = 0;
      next_cfg = CFG_INTERVAL;
      while (counted < RANDOM_BYTES) begin
         if (counted >= next_cfg) begin
            settle();
            write_max_payload(pick_max());
            next_cfg += CFG_INTERVAL;
            no_idle = ($urandom_range(4, 0) == 0);
         end
         pick = $urandom_range(99, 0);
         if (pick < 80) begin
            // well-formed frame, some with a broken trailer
            pick = $urandom_range(99, 0);
            if (pick < 80) n = $urandom_range(12, 0);
            else if (pick < 98) n = $urandom_range(40, 0);
            else n = $urandom_range(max_len, 0);
            if (n > max_len) n = max_len;
            queue_frame(random_body(n),
                        ($urandom_range(7, 0) == 0) ? 16'($urandom_range(65535, 1)) : 16'h0000);
         end else if (pick < 87) begin
            case ($urandom_range(2, 0))
               0:       bad_len = {SYNC_SECOND, SYNC_FIRST};
               1:       bad_len = {SYNC_FIRST, 8'($urandom_range(255, 0))};
               default: bad_len = 16'($urandom_range(65535, max_len + 1));
            endcase
            queue_header(bad_len[7:0], bad_len[15:8]);
         end else if (pick < 93 && max_len >= 2) begin
            // cut a frame short; the next bytes land inside it
            n = $urandom_range((max_len < 12) ? max_len : 12, 2);
            queue_header(8'(n), 8'h00);
            tx_bytes = {tx_bytes, random_body($urandom_range(n - 1, 0))};
         end else begin
            repeat ($urandom_range(8, 1)) begin
               tx_bytes.push_back(($urandom_range(3, 0) == 0) ? SYNC_FIRST :
                                  8'($urandom_range(255, 0)));
            end
            send_queued();
            continue;
         end
         counted += tx_bytes.size();
         send_queued();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_rx_byte     = 8'h00;
      csr_valid       = 1'b0;
      csr_max_payload = 9'd0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_length_limits();
      test_output_backpressure();
      test_random_stream();

      settle();
      if (failures == 0 && expected_events.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/sld_pkg.sv
sv/sld_core.sv
sv/sync_length_crc_deframer_top.sv
tb/tb.sv
